// ----- rtl/core/lfu_pkg.sv -----
// shared types and constants of the lfu cache
`default_nettype none

package lfu_pkg;

  // default sizes
  localparam int CAPACITY_DEF   = 16;
  localparam int COUNT_BITS_DEF = 16;

  // field widths
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int CAP_W  = 5;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // capacity register reset value
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // register index (byte address bit 2 selects the register)
  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_NONE     = 1'b1
  } reg_idx_e;

  // operation code
  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } mode_e;

  // request beat
  typedef struct packed {
    mode_e             mode;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } req_t;

  // result beat
  typedef struct packed {
    logic              hit;
    logic [VAL_W-1:0]  read_value;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/lfu_entries.sv -----
// entry storage of the lfu cache: keys, values, use counts, recency ranks
`default_nettype none

module lfu_entries #(
  parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int UW = $clog2(CAPACITY + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // update command
  input  wire logic                      upd_en_i,
  input  wire logic [IW-1:0]             upd_idx_i,
  input  wire logic [IW-1:0]             age_lim_i,
  input  wire logic                      new_i,
  input  wire logic                      wr_value_i,
  input  wire logic [lfu_pkg::KEY_W-1:0] key_i,
  input  wire logic [lfu_pkg::VAL_W-1:0] value_i,
  // stored state
  output logic [CAPACITY-1:0]            valid_o,
  output logic [lfu_pkg::KEY_W-1:0]      key_o   [CAPACITY],
  output logic [lfu_pkg::VAL_W-1:0]      value_o [CAPACITY],
  output logic [COUNT_BITS-1:0]          count_o [CAPACITY],
  output logic [IW-1:0]                  rec_o   [CAPACITY],
  output logic [UW-1:0]                  used_o
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  logic [CAPACITY-1:0]       valid_q, valid_d;
  logic [lfu_pkg::KEY_W-1:0] key_q   [CAPACITY];
  logic [lfu_pkg::VAL_W-1:0] value_q [CAPACITY];
  logic [COUNT_BITS-1:0]     count_q [CAPACITY];
  logic [IW-1:0]             rec_q   [CAPACITY];
  logic [UW-1:0]             used_q, used_d;

  // valid bits and fill count
  always_comb begin
    valid_d = valid_q;
    used_d  = used_q;
    if (upd_en_i && new_i) begin
      valid_d[upd_idx_i] = 1'b1;
      if (!valid_q[upd_idx_i]) begin
        used_d = used_q + UW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
    end else begin
      valid_q <= valid_d;
      used_q  <= used_d;
    end
  end

  // per-entry payload: target entry is written, younger valid entries age by one
  always_ff @(posedge clk_i) begin
    if (upd_en_i) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (IW'(i) == upd_idx_i) begin
          rec_q[i] <= '0;
          if (new_i) begin
            key_q[i]   <= key_i;
            value_q[i] <= value_i;
            count_q[i] <= COUNT_ONE;
          end else begin
            if (wr_value_i) begin
              value_q[i] <= value_i;
            end
            if (count_q[i] != COUNT_MAX) begin
              count_q[i] <= count_q[i] + COUNT_ONE;
            end
          end
        end else if (valid_q[i] && (rec_q[i] < age_lim_i)) begin
          rec_q[i] <= rec_q[i] + IW'(1);
        end
      end
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign value_o = value_q;
  assign count_o = count_q;
  assign rec_o   = rec_q;
  assign used_o  = used_q;

`ifndef ASSERT_OFF
  // fill count tracks the number of valid entries
  a_used_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    UW'($countones(valid_q)) == used_q)
    else $error("fill count differs from valid entries");

  // fill count never passes the table size
  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(CAPACITY))
    else $error("fill count above table size");

  // an update of a present entry never targets an invalid slot
  a_touch_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_en_i && !new_i) |-> valid_q[upd_idx_i])
    else $error("touch of an invalid entry");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/lfu_lookup.sv -----
// lookup of the lfu cache: key match, lfu/lru victim tree, free slot search
`default_nettype none

module lfu_lookup #(
  parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int UW = $clog2(CAPACITY + 1)
) (
  input  wire logic [lfu_pkg::KEY_W-1:0] key_i,
  input  wire logic [UW-1:0]             limit_i,
  input  wire logic [CAPACITY-1:0]       valid_i,
  input  wire logic [lfu_pkg::KEY_W-1:0] key_tab_i   [CAPACITY],
  input  wire logic [lfu_pkg::VAL_W-1:0] value_tab_i [CAPACITY],
  input  wire logic [COUNT_BITS-1:0]     count_tab_i [CAPACITY],
  input  wire logic [IW-1:0]             rec_tab_i   [CAPACITY],
  input  wire logic [UW-1:0]             used_i,
  output logic                           hit_o,
  output logic [lfu_pkg::VAL_W-1:0]      hit_value_o,
  output logic [IW-1:0]                  idx_o,
  output logic [IW-1:0]                  age_lim_o
);

  localparam int LVL = $clog2(CAPACITY);
  localparam int P   = 1 << LVL;
  localparam int N   = 2 * P - 1;
  localparam int SW  = COUNT_BITS + IW;

  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] free_idx;
  logic          evict;
  logic [IW-1:0] victim_idx;

  // parallel key compare
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (valid_i[i] && (key_tab_i[i] == key_i)) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  // lowest-numbered invalid entry
  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_i[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  // victim tree: lowest count, then oldest rank; lower index wins a tie
  logic          nd_vld [N];
  logic [SW-1:0] nd_key [N];
  logic [IW-1:0] nd_idx [N];

  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < CAPACITY) begin : g_used
      assign nd_vld[P-1+j] = valid_i[j];
      assign nd_key[P-1+j] = {count_tab_i[j], ~rec_tab_i[j]};
      assign nd_idx[P-1+j] = IW'(j);
    end else begin : g_pad
      assign nd_vld[P-1+j] = 1'b0;
      assign nd_key[P-1+j] = '0;
      assign nd_idx[P-1+j] = '0;
    end
  end

  for (genvar n = 0; n < P - 1; n++) begin : g_node
    logic pick_left;
    assign pick_left = nd_vld[2*n+1] &&
                       (!nd_vld[2*n+2] || (nd_key[2*n+1] <= nd_key[2*n+2]));
    assign nd_vld[n] = nd_vld[2*n+1] || nd_vld[2*n+2];
    assign nd_key[n] = pick_left ? nd_key[2*n+1] : nd_key[2*n+2];
    assign nd_idx[n] = pick_left ? nd_idx[2*n+1] : nd_idx[2*n+2];
  end

  assign victim_idx = nd_idx[0];
  assign evict      = (used_i >= limit_i);

  // target entry and aging limit
  always_comb begin
    if (hit) begin
      idx_o     = hit_idx;
      age_lim_o = rec_tab_i[hit_idx];
    end else if (evict) begin
      idx_o     = victim_idx;
      age_lim_o = rec_tab_i[victim_idx];
    end else begin
      idx_o     = free_idx;
      age_lim_o = IW'(CAPACITY - 1);
    end
  end

  assign hit_o       = hit;
  assign hit_value_o = value_tab_i[hit_idx];

endmodule

`default_nettype wire

// ----- rtl/core/lfu_cache.sv -----
// top level of the lfu cache with lru tie-break
//
//  channel   | signals                                      | handshake
//  ----------+----------------------------------------------+----------------------------
//  request   | start_i, busy_o, req_i (mode, key, value)    | beat taken when start_i & !busy_o
//  result    | done_o, rsp_o (hit, read_value)              | one-cycle strobe, no stall
//  config    | psel, penable, pwrite, paddr, pwdata, prdata | apb, pready always high
//
//  one request a cycle; busy_o stays low
//  a result strobes after its request beat passes through the input register,
//  lookup and entry update, result register
//  the key compare, the victim tree and the entry write all sit in the same cycle
//  reset clears the valid bits and the fill count at once, no clearing pass
`default_nettype none

module lfu_cache #(
  parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // request
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire lfu_pkg::req_t               req_i,
  // result
  output logic                             done_o,
  output lfu_pkg::rsp_t                    rsp_o,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lfu_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lfu_pkg::DATA_W-1:0]  pwdata,
  output logic [lfu_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int UW = $clog2(CAPACITY + 1);
  localparam int CW = (UW > lfu_pkg::CAP_W) ? UW : lfu_pkg::CAP_W;

  // configuration register
  logic [lfu_pkg::CAP_W-1:0] cap_q;
  lfu_pkg::reg_idx_e         reg_sel;
  logic                      cfg_wr;

  assign reg_sel = lfu_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lfu_pkg::CAP_RESET;
    end else if (cfg_wr && (reg_sel == lfu_pkg::REG_CAPACITY)) begin
      cap_q <= pwdata[lfu_pkg::CAP_W-1:0];
    end
  end

  // register read
  always_comb begin
    unique case (reg_sel)
      lfu_pkg::REG_CAPACITY: prdata = lfu_pkg::DATA_W'(cap_q);
      default:               prdata = '0;
    endcase
  end

  // live entry limit: zero acts as one, clipped at the table size
  logic [CW-1:0] cap_ext;
  logic [UW-1:0] limit;

  assign cap_ext = CW'(cap_q);

  always_comb begin
    priority if (cap_ext == '0) begin
      limit = UW'(1);
    end else if (cap_ext > CW'(CAPACITY)) begin
      limit = UW'(CAPACITY);
    end else begin
      limit = UW'(cap_ext);
    end
  end

  // input register
  logic          req_vld_q;
  lfu_pkg::req_t req_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
  end

  // entry storage and lookup
  logic [CAPACITY-1:0]       valid;
  logic [lfu_pkg::KEY_W-1:0] key_tab   [CAPACITY];
  logic [lfu_pkg::VAL_W-1:0] value_tab [CAPACITY];
  logic [COUNT_BITS-1:0]     count_tab [CAPACITY];
  logic [IW-1:0]             rec_tab   [CAPACITY];
  logic [UW-1:0]             used;
  logic                      hit;
  logic [lfu_pkg::VAL_W-1:0] hit_value;
  logic [IW-1:0]             upd_idx;
  logic [IW-1:0]             age_lim;
  logic                      is_put;
  logic                      upd_en;

  assign is_put = (req_q.mode == lfu_pkg::MODE_PUT);
  assign upd_en = req_vld_q && (hit || is_put);

  lfu_lookup #(
    .CAPACITY   (CAPACITY),
    .COUNT_BITS (COUNT_BITS)
  ) u_lookup (
    .key_i       (req_q.key),
    .limit_i     (limit),
    .valid_i     (valid),
    .key_tab_i   (key_tab),
    .value_tab_i (value_tab),
    .count_tab_i (count_tab),
    .rec_tab_i   (rec_tab),
    .used_i      (used),
    .hit_o       (hit),
    .hit_value_o (hit_value),
    .idx_o       (upd_idx),
    .age_lim_o   (age_lim)
  );

  lfu_entries #(
    .CAPACITY   (CAPACITY),
    .COUNT_BITS (COUNT_BITS)
  ) u_entries (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_en_i   (upd_en),
    .upd_idx_i  (upd_idx),
    .age_lim_i  (age_lim),
    .new_i      (!hit),
    .wr_value_i (is_put),
    .key_i      (req_q.key),
    .value_i    (req_q.value),
    .valid_o    (valid),
    .key_o      (key_tab),
    .value_o    (value_tab),
    .count_o    (count_tab),
    .rec_o      (rec_tab),
    .used_o     (used)
  );

  // result register
  logic          done_q;
  lfu_pkg::rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      rsp_q.hit        <= hit;
      rsp_q.read_value <= (hit && !is_put) ? hit_value : '0;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef ASSERT_OFF
  // every request beat yields a result after the input and result registers
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("request beat without result");

  // no result without a request beat
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req_vld_q))
    else $error("result without request");

  // a put never returns data
  a_put_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_vld_q && is_put) |=> (rsp_o.read_value == '0))
    else $error("put returned data");

  // a miss never returns data
  a_miss_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.hit) |-> (rsp_o.read_value == '0))
    else $error("miss returned data");
`endif

endmodule

`default_nettype wire
